// ----- rtl/core/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int CMD_W         = 2;
  localparam int SLOT_W        = 4;
  localparam int TIME_W        = 16;
  localparam int WORK_W        = 16;
  localparam int PRIO_W        = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // One task slot as held in the slot memory.
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [WORK_W-1:0] remaining;
    logic [PRIO_W-1:0] priority_lvl;
  } entry_t;

  // Best ready task found so far in a scan.
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] arrival;
    logic [WORK_W-1:0] remaining;
    logic [PRIO_W-1:0] priority_lvl;
  } best_t;

endpackage
`default_nettype wire

// ----- rtl/core/pps_ifs.sv -----
// Valid/ready channel interfaces for task commands and tick reports.
`default_nettype none
interface pps_in_if
  import pps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] arrival_time;
  logic [WORK_W-1:0] burst_length;
  logic [PRIO_W-1:0] priority_level;

  modport source (output valid, cmd, slot, arrival_time, burst_length, priority_level,
                  input ready);
  modport sink   (input valid, cmd, slot, arrival_time, burst_length, priority_level,
                  output ready);
endinterface

interface pps_out_if
  import pps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] ran_slot;
  logic              idle;
  logic              finished;
  logic [TIME_W-1:0] finish_time;
  logic              all_done;

  modport source (output valid, ran_slot, idle, finished, finish_time, all_done,
                  input ready);
  modport sink   (input valid, ran_slot, idle, finished, finish_time, all_done,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pps_mem.sv -----
// Slot memory: one write port, one registered read port.
`default_nettype none
module pps_mem
  import pps_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_TASKS,
  parameter int IDX_W = $clog2(DEF_MAX_TASKS)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] wa,
  input  wire entry_t           wd,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] ra,
  output      entry_t           rd_data_r
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pps_scan.sv -----
// Running best-task tracker: one slot compared per cycle.
`default_nettype none
module pps_scan
  import pps_pkg::*;
#(
  parameter int IDX_W = $clog2(DEF_MAX_TASKS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              cmp_vld,
  input  wire logic [IDX_W-1:0]  cmp_idx,
  input  wire logic              cmp_live,
  input  wire entry_t            cmp_entry,
  input  wire logic [TIME_W-1:0] cur_time,
  output      best_t             best_r,
  output      logic [IDX_W-1:0]  best_idx_r
);

  best_t            best_nxt;
  logic [IDX_W-1:0] best_idx_nxt;
  logic             cand;
  logic             better;

  always_comb begin
    cand   = cmp_vld && cmp_live && (cmp_entry.arrival <= cur_time);
    // Slots arrive in ascending order, so strict compares keep the lower slot on a tie.
    better = !best_r.found
          || (cmp_entry.priority_lvl < best_r.priority_lvl)
          || ((cmp_entry.priority_lvl == best_r.priority_lvl)
              && (cmp_entry.arrival < best_r.arrival));
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (start) begin
      best_nxt.found = 1'b0;
    end else if (cand && better) begin
      best_nxt.found        = 1'b1;
      best_nxt.arrival      = cmp_entry.arrival;
      best_nxt.remaining    = cmp_entry.remaining;
      best_nxt.priority_lvl = cmp_entry.priority_lvl;
      best_idx_nxt          = cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.found <= 1'b0;
    end else begin
      best_r.found <= best_nxt.found;
    end
    best_r.arrival      <= best_nxt.arrival;
    best_r.remaining    <= best_nxt.remaining;
    best_r.priority_lvl <= best_nxt.priority_lvl;
    best_idx_r          <= best_idx_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/preemptive_priority_scheduler_top.sv -----
// Preemptive priority scheduler top level: command FSM, slot memory and scan.
// Load and clear beats give no result.
// A tick beat reads every slot in turn through the single read port and
// comparator (ST_SCAN), drains the read pipe (ST_DRAIN), then writes back and
// registers the report (ST_FINISH), waiting there until the output register is free.
// Reset clears slot liveness, time and the report valid; the slot memory is not cleared.
`default_nettype none
module preemptive_priority_scheduler_top
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch
);

  localparam int               IDX_W    = $clog2(MAX_TASKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  // Control state
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  // A slot is live when it is loaded and still has work left
  logic [MAX_TASKS-1:0]   live_r, live_nxt;
  logic [TIME_W-1:0]      time_r, time_nxt;

  // Result register
  logic                   out_vld_r, out_vld_nxt;
  logic [SLOT_W-1:0]      ran_slot_r, ran_slot_nxt;
  logic                   idle_r, idle_nxt;
  logic                   finished_r, finished_nxt;
  logic [TIME_W-1:0]      finish_time_r, finish_time_nxt;
  logic                   all_done_r, all_done_nxt;

  // Memory and scan hookup
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  entry_t                 mem_wd;
  logic                   mem_re;
  entry_t                 mem_rd_data;
  logic                   scan_start;
  best_t                  best;
  logic [IDX_W-1:0]       best_idx;

  cmd_t                   in_cmd;
  logic                   slot_in_range;
  logic [WORK_W-1:0]      new_rem;
  logic                   fin;
  logic [MAX_TASKS-1:0]   live_upd;
  logic [TIME_W-1:0]      time_inc;

  pps_mem #(
    .DEPTH (MAX_TASKS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .wa        (mem_wa),
    .wd        (mem_wd),
    .re        (mem_re),
    .ra        (rd_idx_r),
    .rd_data_r (mem_rd_data)
  );

  pps_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start),
    .cmp_vld    (cmp_vld_r),
    .cmp_idx    (cmp_idx_r),
    .cmp_live   (live_r[cmp_idx_r]),
    .cmp_entry  (mem_rd_data),
    .cur_time   (time_r),
    .best_r     (best),
    .best_idx_r (best_idx)
  );

  assign in_cmd        = cmd_t'(in_ch.cmd);
  assign slot_in_range = 32'(in_ch.slot) < 32'(MAX_TASKS);

  // Winner bookkeeping for the finish cycle
  always_comb begin
    new_rem  = best.remaining - WORK_W'(1);
    fin      = best.found && (new_rem == '0);
    live_upd = live_r;
    if (fin) begin
      live_upd[best_idx] = 1'b0;
    end
    // Saturate time at its maximum
    time_inc = (time_r == TIME_MAX) ? time_r : time_r + TIME_W'(1);
  end

  always_comb begin
    state_nxt       = state_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = rd_idx_r;
    live_nxt        = live_r;
    time_nxt        = time_r;
    out_vld_nxt     = out_vld_r;
    ran_slot_nxt    = ran_slot_r;
    idle_nxt        = idle_r;
    finished_nxt    = finished_r;
    finish_time_nxt = finish_time_r;
    all_done_nxt    = all_done_r;
    mem_we          = 1'b0;
    mem_wa          = IDX_W'(in_ch.slot);
    mem_wd          = '{arrival:      in_ch.arrival_time,
                        remaining:    in_ch.burst_length,
                        priority_lvl: in_ch.priority_level};
    mem_re          = 1'b0;
    scan_start      = 1'b0;

    // Drop the report once the sink takes the beat
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_cmd)
            CMD_LOAD: begin
              if (slot_in_range) begin
                mem_we           = 1'b1;
                live_nxt[mem_wa] = (in_ch.burst_length != '0);
              end
            end
            CMD_TICK: begin
              scan_start = 1'b1;
              rd_idx_nxt = '0;
              state_nxt  = ST_SCAN;
            end
            CMD_CLEAR: begin
              live_nxt = '0;
              time_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Read one slot per cycle; compare it the cycle after
        mem_re      = 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_vld_r || out_ch.ready) begin
          if (best.found) begin
            mem_we = 1'b1;
            mem_wa = best_idx;
            mem_wd = '{arrival:      best.arrival,
                       remaining:    new_rem,
                       priority_lvl: best.priority_lvl};
          end
          live_nxt        = live_upd;
          time_nxt        = time_inc;
          out_vld_nxt     = 1'b1;
          ran_slot_nxt    = best.found ? SLOT_W'(best_idx) : '0;
          idle_nxt        = !best.found;
          finished_nxt    = fin;
          finish_time_nxt = time_inc;
          all_done_nxt    = ~|live_upd;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      live_r    <= '0;
      time_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      live_r    <= live_nxt;
      time_r    <= time_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    ran_slot_r    <= ran_slot_nxt;
    idle_r        <= idle_nxt;
    finished_r    <= finished_nxt;
    finish_time_r <= finish_time_nxt;
    all_done_r    <= all_done_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.ran_slot    = ran_slot_r;
  assign out_ch.idle        = idle_r;
  assign out_ch.finished    = finished_r;
  assign out_ch.finish_time = finish_time_r;
  assign out_ch.all_done    = all_done_r;

endmodule
`default_nettype wire

// ----- bench/pps_sched_scoreboard_pkg.sv -----
// Scoreboard for the priority scheduler bench: table predictor and report checker.
package pps_sched_scoreboard_pkg;
  import pps_pkg::*;

  localparam int SLOTS = DEF_MAX_TASKS;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [SLOT_W-1:0] ran_slot;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic              all_done;
  } tick_report_t;

  class sched_scoreboard;
    logic [TIME_W-1:0] arrival_tab [SLOTS];
    logic [WORK_W-1:0] work_tab [SLOTS];
    logic [PRIO_W-1:0] prio_tab [SLOTS];
    bit                slot_live [SLOTS];
    logic [TIME_W-1:0] clock_now;
    tick_report_t      due_reports [$];
    int                mismatches;

    function new();
      mismatches = 0;
      clock_now  = '0;
      foreach (slot_live[i]) begin
        slot_live[i]   = 1'b0;
        arrival_tab[i] = '0;
        work_tab[i]    = '0;
        prio_tab[i]    = '0;
      end
    endfunction

    function int pending_count();
      return due_reports.size();
    endfunction

    // Pick the best ready slot, charge it one unit and advance the clock.
    function tick_report_t run_tick();
      tick_report_t rep;
      bit           found;
      bit           any_left;
      int           best;
      found    = 1'b0;
      any_left = 1'b0;
      best     = 0;
      rep      = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && work_tab[i] != '0 && arrival_tab[i] <= clock_now) begin
          if (!found || prio_tab[i] < prio_tab[best] ||
              (prio_tab[i] == prio_tab[best] && arrival_tab[i] < arrival_tab[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        work_tab[best] = work_tab[best] - 1'b1;
        rep.finished   = (work_tab[best] == '0);
        rep.ran_slot   = SLOT_W'(best);
      end
      rep.idle = !found;
      if (clock_now != TIME_MAX) clock_now = clock_now + 1'b1;
      rep.finish_time = clock_now;
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i] && work_tab[i] != '0) any_left = 1'b1;
      rep.all_done = !any_left;
      return rep;
    endfunction

    function void note_beat(input logic [CMD_W-1:0]  cmd,
                            input logic [SLOT_W-1:0] slot,
                            input logic [TIME_W-1:0] arrival,
                            input logic [WORK_W-1:0] burst,
                            input logic [PRIO_W-1:0] prio);
      case (cmd)
        CMD_LOAD: begin
          if (int'(slot) < SLOTS) begin
            arrival_tab[slot] = arrival;
            work_tab[slot]    = burst;
            prio_tab[slot]    = prio;
            slot_live[slot]   = 1'b1;
          end
        end
        CMD_CLEAR: begin
          foreach (slot_live[i]) slot_live[i] = 1'b0;
          clock_now = '0;
        end
        CMD_TICK: due_reports.insert(due_reports.size(), run_tick());
        default: ;
      endcase
    endfunction

    task report(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_report(input tick_report_t got);
      tick_report_t want;
      if (due_reports.size() == 0) begin
        report("tick report arrived with none due");
        return;
      end
      want = due_reports.pop_front();
      if (got.ran_slot !== want.ran_slot)
        report($sformatf("ran_slot %0d, expected %0d", got.ran_slot, want.ran_slot));
      if (got.idle !== want.idle)
        report($sformatf("idle %0b, expected %0b", got.idle, want.idle));
      if (got.finished !== want.finished)
        report($sformatf("finished %0b, expected %0b", got.finished, want.finished));
      if (got.finish_time !== want.finish_time)
        report($sformatf("finish_time %0d, expected %0d", got.finish_time, want.finish_time));
      if (got.all_done !== want.all_done)
        report($sformatf("all_done %0b, expected %0b", got.all_done, want.all_done));
    endtask

    task final_check();
      if (due_reports.size() != 0)
        report($sformatf("%0d tick reports never arrived", due_reports.size()));
    endtask
  endclass

endpackage

// ----- bench/preemptive_priority_scheduler_top_test.sv -----
// Self-checking bench for the preemptive priority scheduler top level.
module preemptive_priority_scheduler_top_test;
  import pps_pkg::*;
  import pps_sched_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A tick beat passes through the scan, drain and finish states in the block, so the
  // idle tail at the end covers anything still in flight.
  localparam int TAIL_CYCLES    = 40;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES    = 600;
  // Cycles with no beat on either channel before the run is declared hung.
  // Longest legal quiet stretch is the hold-off above followed by a scan.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BEATS   = 800;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pps_in_if  in_bus ();
  pps_out_if out_bus ();

  preemptive_priority_scheduler_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  sched_scoreboard sched_sb = new();

  // Shared pacing controls: steady turns off idling on both sides, hold_req
  // asks the result side for one long hold-off.
  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int beats_sent = 0;
  int stall_cycles = 0;

  // Mostly short gaps, now and then a long one.
  function int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 70);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: sample both channels at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sched_sb.note_beat(in_bus.cmd, in_bus.slot, in_bus.arrival_time,
                         in_bus.burst_length, in_bus.priority_level);
  end

  always @(posedge clk) begin
    tick_report_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.ran_slot    = out_bus.ran_slot;
      got.idle        = out_bus.idle;
      got.finished    = out_bus.finished;
      got.finish_time = out_bus.finish_time;
      got.all_done    = out_bus.all_done;
      sched_sb.check_report(got);
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request,
  // counted here so the sender keeps offering beats meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : report_sink
    int stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) stall_left = gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side.
  // ---------------------------------------------------------------------------

  // Offer one beat, optionally after a gap, and hold it until accepted.
  // Valid stays high between back-to-back beats.
  task send_beat(input logic [CMD_W-1:0]  cmd,
                 input logic [SLOT_W-1:0] slot,
                 input logic [TIME_W-1:0] arrival,
                 input logic [WORK_W-1:0] burst,
                 input logic [PRIO_W-1:0] prio);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.cmd            <= cmd;
    in_bus.slot           <= slot;
    in_bus.arrival_time   <= arrival;
    in_bus.burst_length   <= burst;
    in_bus.priority_level <= prio;
    in_bus.valid          <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    if (cmd != CMD_UNKNOWN) beats_sent++;
  endtask

  // Tick, clear or unknown command with junk in the unused fields.
  task send_bare(input logic [CMD_W-1:0] cmd);
    send_beat(cmd, SLOT_W'($urandom), TIME_W'($urandom), WORK_W'($urandom),
              PRIO_W'($urandom));
  endtask

  // Load with values biased toward tasks that are ready soon, short and
  // competing on priority; some full-range values mixed in.
  task load_random();
    int roll;
    int arrival;
    int burst;
    int prio;
    roll = $urandom_range(0, 99);
    if (roll < 70)      arrival = int'(sched_sb.clock_now) + $urandom_range(0, 4);
    else if (roll < 85) arrival = $urandom_range(0, 3);
    else                arrival = $urandom_range(0, 65535);
    if (arrival > 65535) arrival = 65535;
    roll = $urandom_range(0, 99);
    if (roll < 10)      burst = 0;
    else if (roll < 85) burst = $urandom_range(1, 6);
    else if (roll < 95) burst = $urandom_range(7, 40);
    else                burst = $urandom_range(0, 65535);
    prio = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    send_beat(CMD_LOAD, SLOT_W'($urandom_range(0, 15)), TIME_W'(arrival),
              WORK_W'(burst), PRIO_W'(prio));
  endtask

  // Pause the sender until every report due has come back.
  task drain_wait();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sched_sb.pending_count() != 0) @(posedge clk);
  endtask

  // One well-formed schedule (clear, loads, ticks) with preempting loads,
  // unknown commands and stray clears sprinkled in.
  task run_scenario(input bit pressure);
    int n_loads;
    int budget;
    int roll;
    steady = pressure || ($urandom_range(0, 4) == 0);
    if (pressure) hold_req = 1'b1;
    if ($urandom_range(0, 3) != 0) send_bare(CMD_CLEAR);
    n_loads = $urandom_range(1, 6);
    repeat (n_loads) load_random();
    budget = pressure ? 30 : $urandom_range(4, 40);
    repeat (budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)      send_bare(CMD_TICK);
      else if (roll < 92) load_random();
      else if (roll < 97) send_bare(CMD_UNKNOWN);
      else                send_bare(CMD_CLEAR);
    end
  endtask

  initial begin : stimulus
    int scenario_idx;
    in_bus.valid          = 1'b0;
    in_bus.cmd            = CMD_LOAD;
    in_bus.slot           = '0;
    in_bus.arrival_time   = '0;
    in_bus.burst_length   = '0;
    in_bus.priority_level = '0;

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed schedule ----
    send_bare(CMD_TICK);                          // empty table: idle tick
    send_beat(CMD_LOAD, 4'd0, 16'd0, 16'd0, 8'd0);           // zero burst, never runs
    send_beat(CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);   // all fields at max
    send_beat(CMD_LOAD, 4'd3, 16'd2, 16'd2, 8'd5);
    send_beat(CMD_LOAD, 4'd7, 16'd1, 16'd1, 8'd5);           // same level, earlier arrival
    send_beat(CMD_LOAD, 4'd9, 16'd1, 16'd1, 8'd5);           // full tie: lower slot wins
    send_bare(CMD_TICK);
    send_bare(CMD_TICK);
    send_beat(CMD_LOAD, 4'd4, 16'd0, 16'd3, 8'd1);           // preempts slot 3
    send_bare(CMD_TICK);
    send_bare(CMD_UNKNOWN);                                  // must change nothing
    send_bare(CMD_TICK);
    send_beat(CMD_LOAD, 4'd4, 16'd0, 16'd1, 8'd200);         // reload a live slot
    send_bare(CMD_TICK);
    send_bare(CMD_TICK);
    send_bare(CMD_TICK);
    send_bare(CMD_TICK);                          // only a far-future task left: idle
    send_bare(CMD_CLEAR);
    send_bare(CMD_TICK);
    drain_wait();

    // ---- Random schedules ----
    beats_sent   = 0;
    scenario_idx = 0;
    while (beats_sent < RANDOM_BEATS) begin
      run_scenario(scenario_idx == 3);
      // Always drain after the back-pressure scenario, sometimes elsewhere.
      if (scenario_idx == 3 || $urandom_range(0, 5) == 0) drain_wait();
      scenario_idx++;
    end
    steady = 1'b0;

    // ---- Wind down ----
    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk);
    sched_sb.final_check();
    if (sched_sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pps_pkg.sv
rtl/core/pps_ifs.sv
rtl/core/pps_mem.sv
rtl/core/pps_scan.sv
rtl/core/preemptive_priority_scheduler_top.sv
bench/pps_sched_scoreboard_pkg.sv
bench/preemptive_priority_scheduler_top_test.sv
